>>> rtl/crtr_pkg.sv
// Shared types, constants and codes of the caption triplet repacer.
`timescale 1ns / 1ps

package crtr_pkg;

   // Field widths fixed by the triplet and register formats
   localparam int TRIP_W    = 24;
   localparam int BYTE_W    = 8;
   localparam int OP_W      = 2;
   localparam int CC_W      = 6;
   localparam int CC608_W   = 3;
   localparam int SRC_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 6;

   // Default caption queue depth
   localparam int QUEUE_DEPTH_DEF = 128;

   // Frame size limit and padding triplet
   localparam logic [CC_W-1:0]   MAX_FRAME_TRIPLETS = 6'd40;
   localparam logic [BYTE_W-1:0] PAD_HEADER         = 8'hFA;

   // Job queue between the front and back parts
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_TRIPLET = 2'd0,
      OP_EMIT    = 2'd1,
      OP_EMPTY   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Work handed from front to back
   typedef enum logic [1:0] {
      JOB_PUSH608 = 2'd0,
      JOB_PUSH708 = 2'd1,
      JOB_SEEN    = 2'd2,
      JOB_EMIT    = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type        kind;
      logic [TRIP_W-1:0]   trip;
   } job_type;

   // Source code of an emitted triplet
   typedef enum logic [SRC_W-1:0] {
      SRC_608 = 2'd0,
      SRC_708 = 2'd1,
      SRC_PAD = 2'd2
   } src_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CC_PER_FRAME = 1'b0,
      CSR_CC608        = 1'b1
   } csr_index_type;

   // Back-end sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

endpackage

>>> rtl/caption_triplet_repacer_unit.sv
// Top level of the caption triplet repacer: registers, front, back, checks.
`timescale 1ns / 1ps
//
// Closed-caption triplet repacer.
// Requests enter on start/req_* and are taken at an edge where start is high
// and busy is low. A triplet request (operation 0) is sorted into the 608 or
// 708 caption queue, or only marks caption data as present when its header
// has bit 1 set and bit 2 clear; operation 2 marks caption data as present;
// operation 1 emits, once data is present, one output frame of cc_per_frame
// triplets (at most 40): 608 triplets first, then 708, then FA 00 00 padding,
// the final one flagged by rsp_last. Results appear on rsp_* for one cycle
// each, marked by rsp_valid; the receiver takes every result and cannot stall
// the block. A four-entry job queue sits between the request side and the
// queue sequencer, which takes one job per cycle while idle. A triplet or
// empty-data mark is done as the sequencer takes it; an emit sends the
// sequencer to its emit state, which issues the triplets back to back, each
// result registered with the queue memory read data. busy rises only while
// the job queue is full, so a request stream stalls only behind an emit.
// csr_* writes the two frame registers; the user must use it only while the
// block is idle, which the block does not enforce. Reset clears registers,
// queues, flags and the job queue; queue memory contents need no clearing.
//

module caption_triplet_repacer_unit
   import crtr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [BYTE_W-1:0]     req_cc_header,
   input  logic [BYTE_W-1:0]     req_cc_data_one,
   input  logic [BYTE_W-1:0]     req_cc_data_two,
   output logic                  rsp_valid,
   output logic [BYTE_W-1:0]     rsp_out_header,
   output logic [BYTE_W-1:0]     rsp_out_data_one,
   output logic [BYTE_W-1:0]     rsp_out_data_two,
   output logic [SRC_W-1:0]      rsp_source,
   output logic                  rsp_overflow_seen,
   output logic                  rsp_last,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);

   logic [CC_W-1:0]     cc_per_frame_ff, cc_per_frame_in;
   logic [CC608_W-1:0]  cc608_ff, cc608_in;
   logic                job_valid;
   job_type             job;
   logic                job_pop;

   // Decode register writes
   always_comb begin
      cc_per_frame_in = cc_per_frame_ff;
      cc608_in        = cc608_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CC_PER_FRAME: cc_per_frame_in = csr_wdata[CC_W-1:0];
            CSR_CC608:        cc608_in        = csr_wdata[CC608_W-1:0];
            default:          cc608_in        = cc608_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_per_frame_ff <= '0;
         cc608_ff        <= '0;
      end else begin
         cc_per_frame_ff <= cc_per_frame_in;
         cc608_ff        <= cc608_in;
      end
   end

   crtr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_cc_header   (req_cc_header),
      .req_cc_data_one (req_cc_data_one),
      .req_cc_data_two (req_cc_data_two),
      .cc_per_frame    (cc_per_frame_ff),
      .job_valid       (job_valid),
      .job             (job),
      .job_pop         (job_pop)
   );

   crtr_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock             (clock),
      .reset             (reset),
      .cc_per_frame      (cc_per_frame_ff),
      .cc608_per_frame   (cc608_ff),
      .job_valid         (job_valid),
      .job               (job),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_out_header    (rsp_out_header),
      .rsp_out_data_one  (rsp_out_data_one),
      .rsp_out_data_two  (rsp_out_data_two),
      .rsp_source        (rsp_source),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_last          (rsp_last)
   );

   // A frame runs without gaps until its last triplet
   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("output frame interrupted before its last triplet");

   // Within a frame the source never goes back (608, then 708, then padding)
   a_source_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(rsp_last) |->
         rsp_source >= $past(rsp_source))
      else $error("triplet source order broken within a frame");

   // The overflow flag is sticky across results
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && $past(rsp_overflow_seen) |-> rsp_overflow_seen)
      else $error("overflow flag cleared without reset");

   // Sequencer pulls jobs only when the job queue holds one
   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("job taken from an empty job queue");

endmodule

>>> rtl/crtr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module crtr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/crtr_front.sv
// Front part: accept requests, classify them and queue jobs for the back part.
`timescale 1ns / 1ps

module crtr_front
   import crtr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [BYTE_W-1:0]   req_cc_header,
   input  logic [BYTE_W-1:0]   req_cc_data_one,
   input  logic [BYTE_W-1:0]   req_cc_data_two,
   input  logic [CC_W-1:0]     cc_per_frame,
   output logic                job_valid,
   output job_type             job,
   input  logic                job_pop
);

   job_type                fifo_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff, count_in;
   logic                   enq;
   job_kind_type           enq_kind;
   logic                   enabled;
   logic                   do_pop;

   assign enabled = (cc_per_frame != '0);
   assign busy    = (count_ff == JOB_CNT_W'(JOB_DEPTH));

   // Classify the request into a job, or drop it
   always_comb begin
      enq      = 1'b0;
      enq_kind = JOB_SEEN;
      if (start && !busy && enabled) begin
         unique case (op_type'(req_operation))
            OP_TRIPLET: begin
               enq = 1'b1;
               if (!req_cc_header[1]) begin
                  enq_kind = JOB_PUSH608;
               end else if (req_cc_header[2]) begin
                  enq_kind = JOB_PUSH708;
               end else begin
                  enq_kind = JOB_SEEN;
               end
            end
            OP_EMPTY: begin
               enq      = 1'b1;
               enq_kind = JOB_SEEN;
            end
            OP_EMIT: begin
               enq      = 1'b1;
               enq_kind = JOB_EMIT;
            end
            OP_NONE: begin
               enq = 1'b0;
            end
            default: begin
               enq = 1'b0;
            end
         endcase
      end
   end

   assign do_pop    = job_pop && job_valid;
   assign job_valid = (count_ff != '0);
   assign job       = fifo_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job payload
   always_ff @(posedge clock) begin
      if (enq) begin
         fifo_ff[wr_ptr_ff] <= '{kind: enq_kind,
                                 trip: {req_cc_header, req_cc_data_one, req_cc_data_two}};
      end
   end

endmodule

>>> rtl/crtr_back.sv
// Back part: caption queues, frame sequencer and result output stage.
`timescale 1ns / 1ps

module crtr_back
   import crtr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CC_W-1:0]     cc_per_frame,
   input  logic [CC608_W-1:0]  cc608_per_frame,
   input  logic                job_valid,
   input  job_type             job,
   output logic                job_pop,
   output logic                rsp_valid,
   output logic [BYTE_W-1:0]   rsp_out_header,
   output logic [BYTE_W-1:0]   rsp_out_data_one,
   output logic [BYTE_W-1:0]   rsp_out_data_two,
   output logic [SRC_W-1:0]    rsp_source,
   output logic                rsp_overflow_seen,
   output logic                rsp_last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

   state_type            state_ff, state_in;
   logic [CC_W-1:0]      k_ff, k_in;
   logic [CC_W-1:0]      n_ff, n_in;
   logic [CC608_W-1:0]   n608_ff, n608_in;
   logic [OCC_W-1:0]     occ608_ff, occ608_in, occ708_ff, occ708_in;
   logic [PTR_W-1:0]     rd608_ff, rd608_in, wr608_ff, wr608_in;
   logic [PTR_W-1:0]     rd708_ff, rd708_in, wr708_ff, wr708_in;
   logic                 seen_ff, seen_in;
   logic                 ovf_ff, ovf_in;
   logic                 out_valid_ff, out_valid_in;
   src_type              out_src_ff, out_src_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic                 wr608_en, wr708_en, rd608_en, rd708_en;
   logic [TRIP_W-1:0]    rdata608, rdata708, out_trip;
   logic [CC_W-1:0]      n_calc;
   logic [CC608_W-1:0]   n608_calc;
   logic                 start_emit;
   logic                 last_issue;

   // Frame size and 608 share for a new frame
   always_comb begin
      n_calc    = (cc_per_frame > MAX_FRAME_TRIPLETS) ? MAX_FRAME_TRIPLETS : cc_per_frame;
      n608_calc = ({{(CC_W-CC608_W){1'b0}}, cc608_per_frame} > n_calc) ?
                  n_calc[CC608_W-1:0] : cc608_per_frame;
   end

   assign start_emit = job_valid && (job.kind == JOB_EMIT) && seen_ff && (n_calc != '0);
   assign last_issue = (k_ff == n_ff - 1'b1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_emit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Job execution and triplet issue
   always_comb begin
      job_pop      = 1'b0;
      wr608_en     = 1'b0;
      wr708_en     = 1'b0;
      rd608_en     = 1'b0;
      rd708_en     = 1'b0;
      k_in         = k_ff;
      n_in         = n_ff;
      n608_in      = n608_ff;
      occ608_in    = occ608_ff;
      occ708_in    = occ708_ff;
      rd608_in     = rd608_ff;
      wr608_in     = wr608_ff;
      rd708_in     = rd708_ff;
      wr708_in     = wr708_ff;
      seen_in      = seen_ff;
      ovf_in       = ovf_ff;
      out_valid_in = 1'b0;
      out_src_in   = out_src_ff;
      out_last_in  = 1'b0;
      out_ovf_in   = out_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               unique case (job.kind)
                  JOB_PUSH608: begin
                     seen_in = 1'b1;
                     if (occ608_ff == OCC_FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr608_en  = 1'b1;
                        wr608_in  = (wr608_ff == PTR_LAST) ? '0 : wr608_ff + 1'b1;
                        occ608_in = occ608_ff + 1'b1;
                     end
                  end
                  JOB_PUSH708: begin
                     seen_in = 1'b1;
                     if (occ708_ff == OCC_FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr708_en  = 1'b1;
                        wr708_in  = (wr708_ff == PTR_LAST) ? '0 : wr708_ff + 1'b1;
                        occ708_in = occ708_ff + 1'b1;
                     end
                  end
                  JOB_SEEN: begin
                     seen_in = 1'b1;
                  end
                  JOB_EMIT: begin
                     k_in    = '0;
                     n_in    = n_calc;
                     n608_in = n608_calc;
                  end
                  default: begin
                     seen_in = seen_ff;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // Take from 608 first, then 708, then pad
            priority if ((k_ff < {{(CC_W-CC608_W){1'b0}}, n608_ff}) && (occ608_ff != '0)) begin
               rd608_en   = 1'b1;
               rd608_in   = (rd608_ff == PTR_LAST) ? '0 : rd608_ff + 1'b1;
               occ608_in  = occ608_ff - 1'b1;
               out_src_in = SRC_608;
            end else if (occ708_ff != '0) begin
               rd708_en   = 1'b1;
               rd708_in   = (rd708_ff == PTR_LAST) ? '0 : rd708_ff + 1'b1;
               occ708_in  = occ708_ff - 1'b1;
               out_src_in = SRC_708;
            end else begin
               out_src_in = SRC_PAD;
            end
            out_valid_in = 1'b1;
            out_last_in  = last_issue;
            out_ovf_in   = ovf_ff;
            k_in         = k_ff + 1'b1;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ608_ff    <= '0;
         occ708_ff    <= '0;
         rd608_ff     <= '0;
         wr608_ff     <= '0;
         rd708_ff     <= '0;
         wr708_ff     <= '0;
         seen_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ608_ff    <= occ608_in;
         occ708_ff    <= occ708_in;
         rd608_ff     <= rd608_in;
         wr608_ff     <= wr608_in;
         rd708_ff     <= rd708_in;
         wr708_ff     <= wr708_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   // Frame counters and output payload
   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      n_ff       <= n_in;
      n608_ff    <= n608_in;
      out_src_ff <= out_src_in;
      out_ovf_ff <= out_ovf_in;
   end

   crtr_ram #(.WIDTH(TRIP_W), .DEPTH(QUEUE_DEPTH)) u_ram608 (
      .clock   (clock),
      .wr_en   (wr608_en),
      .wr_addr (wr608_ff),
      .wr_data (job.trip),
      .rd_en   (rd608_en),
      .rd_addr (rd608_ff),
      .rd_data (rdata608)
   );

   crtr_ram #(.WIDTH(TRIP_W), .DEPTH(QUEUE_DEPTH)) u_ram708 (
      .clock   (clock),
      .wr_en   (wr708_en),
      .wr_addr (wr708_ff),
      .wr_data (job.trip),
      .rd_en   (rd708_en),
      .rd_addr (rd708_ff),
      .rd_data (rdata708)
   );

   // Select the emitted triplet
   always_comb begin
      unique case (out_src_ff)
         SRC_608: out_trip = rdata608;
         SRC_708: out_trip = rdata708;
         default: out_trip = {PAD_HEADER, {(TRIP_W-BYTE_W){1'b0}}};
      endcase
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_header    = out_trip[TRIP_W-1 -: BYTE_W];
   assign rsp_out_data_one  = out_trip[2*BYTE_W-1 -: BYTE_W];
   assign rsp_out_data_two  = out_trip[BYTE_W-1:0];
   assign rsp_source        = out_src_ff;
   assign rsp_overflow_seen = out_ovf_ff;
   assign rsp_last          = out_last_ff;

endmodule
